// ===== rtl/rss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rss_pkg
// Shared widths, register indexes and types of the rgb sharpen stream core.
// ----------------------------------------------------------------------------
package rss_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int FW_W       = 12;
  localparam int FH_W       = 13;
  localparam int WGT_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_WEIGHT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL     = 2'd3;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [2:0][2:0][PIX_W-1:0] win_t;

  // one pixel step handed from the window stage to the result stage
  typedef struct packed {
    win_t             win;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last_row;
    logic             last_col;
  } step_t;

endpackage

// ===== rtl/rss_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rss_pix_if / rss_res_if
// Valid/ready stream channels for input pixels and filtered results.
// ----------------------------------------------------------------------------
interface rss_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  logic       in_start_of_frame;

  modport source (output valid, in_red, in_green, in_blue, in_start_of_frame,
                  input ready);
  modport sink   (input valid, in_red, in_green, in_blue, in_start_of_frame,
                  output ready);
endinterface

interface rss_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [11:0] out_row;
  logic [10:0] out_col;
  logic        out_last_of_run;
  logic        out_end_of_frame;

  modport source (output valid, out_red, out_green, out_blue, out_row, out_col,
                  out_last_of_run, out_end_of_frame, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, out_row, out_col,
                  out_last_of_run, out_end_of_frame, output ready);
endinterface

// ===== rtl/rgb_sharpen_3x3_stream_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_sharpen_3x3_stream_core
// Streaming 3x3 sharpen filter for RGB pixels with border replication.
// ----------------------------------------------------------------------------
// Usage:
//   pix_i takes raster-order pixels; in_start_of_frame restarts at row 0,
//   column 0. res_o sends filtered pixels tagged with row and column; they
//   are not in raster order; each waits for its neighbours below and right.
//   cfg_we_i/cfg_idx_i/cfg_data_i write frame_width, frame_height,
//   centre_weight and max_level (indexes 0..3) while the core is idle.
// Pipeline: a result passes the line store read, window and filter
//   registers after the pixel that completes it is transferred.
// Throughput: one pixel per cycle while res_o is ready and each pixel
//   causes at most one result; a pixel at a row end or in the last row
//   causes up to two and the last pixel of a frame up to four, which leave
//   one per cycle and hold off input. The line memory is read when a pixel
//   is transferred and written back one stage later, possibly in the same
//   cycle as the next read; that write is forwarded to a same-column read.
// Reset: counters, window and config return to defaults (640x480, weight 5,
//   max level 255); line stores are not cleared and need no clearing pass.
// Stall: a stalled receiver holds the result register; the stages behind it
//   fill and then deassert pix_i.ready.
// ----------------------------------------------------------------------------
module rgb_sharpen_3x3_stream_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rss_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rss_pkg::CFG_DATA_W-1:0] cfg_data_i,
  rss_pix_if.sink                       pix_i,
  rss_res_if.source                     res_o
);
  import rss_pkg::*;

  logic [FW_W-1:0]  fw_q;
  logic [FH_W-1:0]  fh_q;
  logic [WGT_W-1:0] wgt_q;
  logic [CH_W-1:0]  max_q;
  logic             step_valid, step_ready;
  step_t            step;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q  <= FW_W'(640);
      fh_q  <= FH_W'(480);
      wgt_q <= WGT_W'(5);
      max_q <= CH_W'(255);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FRAME_WIDTH:   fw_q  <= cfg_data_i[FW_W-1:0];
        CFG_FRAME_HEIGHT:  fh_q  <= cfg_data_i[FH_W-1:0];
        CFG_CENTRE_WEIGHT: wgt_q <= cfg_data_i[WGT_W-1:0];
        CFG_MAX_LEVEL:     max_q <= cfg_data_i[CH_W-1:0];
        default: ;
      endcase
    end
  end

  // line stores and window
  rss_line_buf u_line_buf (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .frame_width_i  (fw_q),
    .frame_height_i (fh_q),
    .in_valid_i     (pix_i.valid),
    .in_ready_o     (pix_i.ready),
    .in_pix_i       ({pix_i.in_blue, pix_i.in_green, pix_i.in_red}),
    .in_sof_i       (pix_i.in_start_of_frame),
    .step_valid_o   (step_valid),
    .step_ready_i   (step_ready),
    .step_o         (step)
  );

  // result sequencing and filter
  rss_emit u_emit (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .centre_weight_i (wgt_q),
    .max_level_i     (max_q),
    .step_valid_i    (step_valid),
    .step_ready_o    (step_ready),
    .step_i          (step),
    .res_o           (res_o)
  );

endmodule

// ===== rtl/rss_line_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rss_line_buf
// Position counters, line store memory with read-modify-write and 3x3 window.
// ----------------------------------------------------------------------------
module rss_line_buf (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [rss_pkg::FW_W-1:0] frame_width_i,
  input  logic [rss_pkg::FH_W-1:0] frame_height_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  rss_pkg::pix_t          in_pix_i,
  input  logic                   in_sof_i,
  output logic                   step_valid_o,
  input  logic                   step_ready_i,
  output rss_pkg::step_t         step_o
);
  import rss_pkg::*;

  // entry holds {upper row, middle row} of one column
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];

  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [FW_W-1:0]  w_eff;
  logic [FH_W-1:0]  h_eff;
  logic [COL_W-1:0] w_m1;
  logic [ROW_W-1:0] h_m1;
  logic [ROW_W-1:0] r_cur;
  logic [COL_W-1:0] c_cur;
  logic             lc_cur, lr_cur;
  logic             accept;

  logic             b_valid_q;
  pix_t             b_pix_q;
  logic [ROW_W-1:0] b_row_q;
  logic [COL_W-1:0] b_col_q;
  logic             b_lr_q, b_lc_q;
  logic [2*PIX_W-1:0] rd_q, fwd_data_q, rd_eff, wr_data;
  logic             fwd_q;
  logic             b_adv;
  win_t             win_q, win_d;

  // frame size clamped to the supported range
  always_comb begin
    w_eff = frame_width_i;
    if (frame_width_i == '0) w_eff = FW_W'(1);
    else if (frame_width_i > FW_W'(MAX_WIDTH)) w_eff = FW_W'(MAX_WIDTH);
    h_eff = frame_height_i;
    if (frame_height_i == '0) h_eff = FH_W'(1);
    else if (frame_height_i > FH_W'(MAX_HEIGHT)) h_eff = FH_W'(MAX_HEIGHT);
  end
  assign w_m1 = COL_W'(w_eff - FW_W'(1));
  assign h_m1 = ROW_W'(h_eff - FH_W'(1));

  // position of the incoming pixel
  assign r_cur  = in_sof_i ? '0 : row_q;
  assign c_cur  = in_sof_i ? '0 : col_q;
  assign lc_cur = c_cur >= w_m1;
  assign lr_cur = r_cur >= h_m1;

  assign b_adv      = b_valid_q & step_ready_i;
  assign in_ready_o = !b_valid_q | step_ready_i;
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (accept) begin
      if (lc_cur) begin
        col_d = '0;
        row_d = lr_cur ? '0 : r_cur + ROW_W'(1);
      end else begin
        row_d = r_cur;
        col_d = c_cur + COL_W'(1);
      end
    end
  end

  // memory read data, with the write of the same edge forwarded
  assign rd_eff  = fwd_q ? fwd_data_q : rd_q;
  assign wr_data = {rd_eff[PIX_W-1:0], b_pix_q};

  // window shift by one column
  always_comb begin
    win_d = win_q;
    for (int k = 0; k < 3; k++) begin
      win_d[k][0] = win_q[k][1];
      win_d[k][1] = win_q[k][2];
    end
    win_d[0][2] = rd_eff[2*PIX_W-1:PIX_W];
    win_d[1][2] = rd_eff[PIX_W-1:0];
    win_d[2][2] = b_pix_q;
  end

  assign step_valid_o     = b_valid_q;
  assign step_o.win       = win_d;
  assign step_o.row       = b_row_q;
  assign step_o.col       = b_col_q;
  assign step_o.last_row  = b_lr_q;
  assign step_o.last_col  = b_lc_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q     <= '0;
      col_q     <= '0;
      b_valid_q <= 1'b0;
      win_q     <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
      if (accept) b_valid_q <= 1'b1;
      else if (b_adv) b_valid_q <= 1'b0;
      if (b_adv) win_q <= win_d;
    end
  end

  // line store read and write back
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q       <= line_mem[c_cur];
      fwd_q      <= b_adv && (b_col_q == c_cur);
      fwd_data_q <= wr_data;
      b_pix_q    <= in_pix_i;
      b_row_q    <= r_cur;
      b_col_q    <= c_cur;
      b_lr_q     <= lr_cur;
      b_lc_q     <= lc_cur;
    end
    if (b_adv) line_mem[b_col_q] <= wr_data;
  end

endmodule

// ===== rtl/rss_emit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rss_emit
// Sequences up to four results per pixel step, filters and clamps them.
// ----------------------------------------------------------------------------
module rss_emit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [rss_pkg::WGT_W-1:0] centre_weight_i,
  input  logic [rss_pkg::CH_W-1:0]  max_level_i,
  input  logic                     step_valid_i,
  output logic                     step_ready_o,
  input  rss_pkg::step_t           step_i,
  rss_res_if.source                res_o
);
  import rss_pkg::*;

  logic [3:0]       mask_q, mask_d, pick, rest;
  step_t            st_q;
  logic             emit, last, bot, rgt, top_b, left_b;
  logic [1:0]       rr, cc;
  pix_t             ce, up, dn, lf, rt;
  logic [CH_W-1:0]  res [3];
  logic             o_valid_q;
  logic [CH_W-1:0]  o_red_q, o_green_q, o_blue_q;
  logic [ROW_W-1:0] o_row_q;
  logic [COL_W-1:0] o_col_q;
  logic             o_last_q, o_eof_q;
  logic [ROW_W-1:0] o_row_d;
  logic [COL_W-1:0] o_col_d;

  // result kinds: bit0 upper-left, bit1 bottom-left, bit2 upper-right,
  // bit3 bottom-right
  always_comb begin
    mask_d[0] = (step_i.col != '0) && (step_i.row != '0);
    mask_d[1] = (step_i.col != '0) && step_i.last_row;
    mask_d[2] = step_i.last_col && (step_i.row != '0);
    mask_d[3] = step_i.last_col && step_i.last_row;
  end

  assign pick = mask_q & (~mask_q + 4'd1);
  assign rest = mask_q & ~pick;
  assign last = rest == '0;
  assign emit = (mask_q != '0) && (!o_valid_q || res_o.ready);
  assign step_ready_o = (mask_q == '0) || (emit && last);

  // operand selection for the picked kind
  always_comb begin
    bot    = pick[1] | pick[3];
    rgt    = pick[2] | pick[3];
    rr     = bot ? 2'd2 : 2'd1;
    cc     = rgt ? 2'd2 : 2'd1;
    top_b  = bot ? (st_q.row == '0) : (st_q.row == ROW_W'(1));
    left_b = rgt ? (st_q.col == '0) : (st_q.col == COL_W'(1));
    ce     = st_q.win[rr][cc];
    up     = top_b ? ce : st_q.win[rr-2'd1][cc];
    dn     = bot ? ce : st_q.win[2][cc];
    lf     = left_b ? ce : st_q.win[rr][cc-2'd1];
    rt     = rgt ? ce : st_q.win[rr][2];
    o_row_d = bot ? st_q.row : st_q.row - ROW_W'(1);
    o_col_d = rgt ? st_q.col : st_q.col - COL_W'(1);
  end

  // per channel weighted centre minus the four neighbours, clamped
  always_comb begin
    logic signed [13:0] v;
    for (int k = 0; k < 3; k++) begin
      v = $signed({2'b0, 12'(centre_weight_i) * 12'(ce[k*CH_W +: CH_W])})
        - $signed({6'b0, up[k*CH_W +: CH_W]}) - $signed({6'b0, dn[k*CH_W +: CH_W]})
        - $signed({6'b0, lf[k*CH_W +: CH_W]}) - $signed({6'b0, rt[k*CH_W +: CH_W]});
      if (v < 0) res[k] = '0;
      else if (v > $signed({6'b0, max_level_i})) res[k] = max_level_i;
      else res[k] = v[CH_W-1:0];
    end
  end

  // control state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q    <= '0;
      o_valid_q <= 1'b0;
    end else begin
      if (step_valid_i && step_ready_o) mask_q <= mask_d;
      else if (emit) mask_q <= rest;
      if (emit) o_valid_q <= 1'b1;
      else if (res_o.ready) o_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_valid_i && step_ready_o) st_q <= step_i;
    if (emit) begin
      o_red_q   <= res[0];
      o_green_q <= res[1];
      o_blue_q  <= res[2];
      o_row_q   <= o_row_d;
      o_col_q   <= o_col_d;
      o_last_q  <= last;
      o_eof_q   <= pick[3];
    end
  end

  assign res_o.valid            = o_valid_q;
  assign res_o.out_red          = o_red_q;
  assign res_o.out_green        = o_green_q;
  assign res_o.out_blue         = o_blue_q;
  assign res_o.out_row          = o_row_q;
  assign res_o.out_col          = o_col_q;
  assign res_o.out_last_of_run  = o_last_q;
  assign res_o.out_end_of_frame = o_eof_q;

endmodule

// ===== rtl/rss_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rss_checker
// Port-level properties of the sharpen core, bound to the top level.
// ----------------------------------------------------------------------------
module rss_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic res_valid,
  input logic res_ready,
  input logic res_last,
  input logic res_eof
);

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  // the bottom-right pixel closes its run
  a_eof_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_eof |-> res_last)
    else $error("end of frame not last of run");

  // the rest of a run follows without a gap
  a_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_ready && !res_last |=> res_valid)
    else $error("gap inside a run");

endmodule

bind rgb_sharpen_3x3_stream_core rss_checker u_rss_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .res_valid (res_o.valid),
  .res_ready (res_o.ready),
  .res_last  (res_o.out_last_of_run),
  .res_eof   (res_o.out_end_of_frame)
);
